// ===== rtl/core/rs_pkg.sv =====
`timescale 1ns / 1ps

package rs_pkg;

  localparam int CW = 16;       // coordinate width
  localparam int XW = CW + 2;   // working width, holds every sum and difference exactly

  typedef logic signed [XW-1:0] coord_t;

  // corner pattern codes: bit 3 top-left, bit 2 bottom-left, bit 1 top-right,
  // bit 0 bottom-right outside point lies inside the base
  localparam logic [3:0] PAT_NONE  = 4'd0;
  localparam logic [3:0] PAT_BR    = 4'd1;
  localparam logic [3:0] PAT_TR    = 4'd2;
  localparam logic [3:0] PAT_TR_BR = 4'd3;
  localparam logic [3:0] PAT_BL    = 4'd4;
  localparam logic [3:0] PAT_BL_BR = 4'd5;
  localparam logic [3:0] PAT_TL    = 4'd8;
  localparam logic [3:0] PAT_TL_TR = 4'd10;
  localparam logic [3:0] PAT_TL_BL = 4'd12;
  localparam logic [3:0] PAT_ALL   = 4'd15;

  typedef struct packed {
    logic signed [CW-1:0] base_x;
    logic signed [CW-1:0] base_y;
    logic [CW-1:0]        base_w;
    logic [CW-1:0]        base_h;
    logic signed [CW-1:0] cut_x;
    logic signed [CW-1:0] cut_y;
    logic [CW-1:0]        cut_w;
    logic [CW-1:0]        cut_h;
  } item_t;

  // edges of both rectangles in working width
  typedef struct packed {
    coord_t bx;
    coord_t by;
    coord_t ex;
    coord_t ey;
    coord_t mnx;
    coord_t mny;
    coord_t mxx;
    coord_t mxy;
  } edges_t;

  // one piece before subtraction: origin, and width/height as a minus b
  typedef struct packed {
    coord_t x;
    coord_t y;
    coord_t wa;
    coord_t wb;
    coord_t ha;
    coord_t hb;
  } ops_t;

  typedef struct packed {
    coord_t x;
    coord_t y;
    coord_t w;
    coord_t h;
  } raw_t;

  typedef struct packed {
    logic signed [CW-1:0] x;
    logic signed [CW-1:0] y;
    logic [CW-1:0]        w;
    logic [CW-1:0]        h;
  } piece_t;

  function automatic ops_t mk(coord_t x, coord_t y, coord_t wa, coord_t wb,
                              coord_t ha, coord_t hb);
    ops_t o;
    o.x  = x;
    o.y  = y;
    o.wa = wa;
    o.wb = wb;
    o.ha = ha;
    o.hb = hb;
    return o;
  endfunction

  // operand selection for one output slot; unused slots give an empty piece
  function automatic ops_t piece_ops(logic [3:0] pat, logic [1:0] slot, edges_t e);
    ops_t o;
    ops_t top;
    o   = '0;
    top = mk(e.bx, e.by, e.ex, e.bx, e.mny, e.by);
    unique case (pat)
      PAT_TL: begin
        if (slot == 2'd0) o = top;
        else if (slot == 2'd1) o = mk(e.bx, e.mny, e.mnx, e.bx, e.ey, e.mny);
      end
      PAT_BL: begin
        if (slot == 2'd0) o = mk(e.bx, e.by, e.mnx, e.bx, e.ey, e.by);
        else if (slot == 2'd1) o = mk(e.mnx, e.mxy, e.ex, e.mnx, e.ey, e.mxy);
      end
      PAT_TR: begin
        if (slot == 2'd0) o = top;
        else if (slot == 2'd1) o = mk(e.mxx, e.mny, e.ex, e.mxx, e.ey, e.mny);
      end
      PAT_BR: begin
        if (slot == 2'd0) o = mk(e.mxx, e.by, e.ex, e.mxx, e.ey, e.by);
        else if (slot == 2'd1) o = mk(e.bx, e.mxy, e.mxx, e.bx, e.ey, e.mxy);
      end
      PAT_TL_TR: begin
        if (slot == 2'd0) o = top;
        else if (slot == 2'd1) o = mk(e.bx, e.mny, e.mnx, e.bx, e.ey, e.mny);
        else if (slot == 2'd2) o = mk(e.mxx, e.mny, e.ex, e.mxx, e.ey, e.mny);
      end
      PAT_TR_BR: begin
        if (slot == 2'd0) o = top;
        else if (slot == 2'd1) o = mk(e.mxx, e.mny, e.ex, e.mxx, e.ey, e.mny);
        else if (slot == 2'd2) o = mk(e.bx, e.mxy, e.mxx, e.bx, e.ey, e.mxy);
      end
      PAT_BL_BR: begin
        if (slot == 2'd0) o = mk(e.bx, e.by, e.mnx, e.bx, e.ey, e.by);
        else if (slot == 2'd1) o = mk(e.mxx, e.by, e.ex, e.mxx, e.ey, e.by);
        else if (slot == 2'd2) o = mk(e.mnx, e.mxy, e.mxx, e.mnx, e.ey, e.mxy);
      end
      PAT_TL_BL: begin
        if (slot == 2'd0) o = top;
        else if (slot == 2'd1) o = mk(e.bx, e.mny, e.mnx, e.bx, e.ey, e.mny);
        else if (slot == 2'd2) o = mk(e.mnx, e.mxy, e.ex, e.mnx, e.ey, e.mxy);
      end
      PAT_ALL: begin
        unique case (slot)
          2'd0: o = mk(e.bx, e.by, e.mxx, e.bx, e.mny, e.by);
          2'd1: o = mk(e.bx, e.mny, e.mnx, e.bx, e.ey, e.mny);
          2'd2: o = mk(e.mnx, e.mxy, e.ex, e.mnx, e.ey, e.mxy);
          default: o = mk(e.mxx, e.by, e.ex, e.mxx, e.mxy, e.by);
        endcase
      end
      PAT_NONE: begin
        unique case (slot)
          2'd0: o = top;
          2'd1: o = mk(e.bx, e.by, e.mnx, e.bx, e.ey, e.by);
          2'd2: o = mk(e.bx, e.mxy, e.ex, e.bx, e.ey, e.mxy);
          default: o = mk(e.mxx, e.by, e.ex, e.mxx, e.ey, e.by);
        endcase
      end
      default: o = '0;
    endcase
    return o;
  endfunction

  // clamp a size to [0, all ones]
  function automatic logic [CW-1:0] sat_size(coord_t d);
    logic [CW-1:0] r;
    if (d[XW-1]) r = '0;
    else if (|d[XW-2:CW]) r = '1;
    else r = d[CW-1:0];
    return r;
  endfunction

endpackage

// ===== rtl/core/rectangle_subtract.sv =====
`timescale 1ns / 1ps

// rectangle subtraction: base minus cut as four pieces. an item (base and cut
// rectangle) is taken on a clock edge with start high and busy low; busy then
// stays high while the hold counter runs down, spacing the items to suit the
// result port, which sends four pieces per item, one per cycle. the first
// piece passes through the edge, corner test, operand select and subtract,
// size clamp and output registers, followed by the other three as back-to-back
// beats with piece_valid high, piece_last high on the fourth. the receiver
// cannot stall: each beat is on the ports for exactly one cycle. empty padding
// pieces are all zero; sizes that compute negative clamp to zero, too large
// clamp to all ones; origins wrap to 16 bits

module rectangle_subtract import rs_pkg::*; (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 start,
  output logic                 busy,
  input  logic signed [CW-1:0] base_x,
  input  logic signed [CW-1:0] base_y,
  input  logic [CW-1:0]        base_w,
  input  logic [CW-1:0]        base_h,
  input  logic signed [CW-1:0] cut_x,
  input  logic signed [CW-1:0] cut_y,
  input  logic [CW-1:0]        cut_w,
  input  logic [CW-1:0]        cut_h,
  output logic                 piece_valid,
  output logic signed [CW-1:0] piece_x,
  output logic signed [CW-1:0] piece_y,
  output logic [CW-1:0]        piece_w,
  output logic [CW-1:0]        piece_h,
  output logic                 piece_last
);

  logic       accept;
  logic [1:0] hold;      // cycles left before the next item may enter
  item_t      item;
  logic       pieces_valid;
  piece_t     pieces [4];

  // serializer: pieces 1..3 wait here while piece 0 goes out
  piece_t     buf_q [4];
  logic       draining;
  logic [1:0] idx;

  assign accept = start && !busy;
  assign busy   = (hold != 2'd0);

  always_comb begin
    item.base_x = base_x;
    item.base_y = base_y;
    item.base_w = base_w;
    item.base_h = base_h;
    item.cut_x  = cut_x;
    item.cut_y  = cut_y;
    item.cut_w  = cut_w;
    item.cut_h  = cut_h;
  end

  // spacing between items keeps the serializer free
  always_ff @(posedge clk) begin
    if (rst) begin
      hold <= 2'd0;
    end else if (accept) begin
      hold <= 2'd3;
    end else if (hold != 2'd0) begin
      hold <= hold - 2'd1;
    end
  end

  rs_pipe u_pipe (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (accept),
    .item         (item),
    .pieces_valid (pieces_valid),
    .pieces       (pieces)
  );

  // control of the output beats
  always_ff @(posedge clk) begin
    if (rst) begin
      piece_valid <= 1'b0;
      piece_last  <= 1'b0;
      draining    <= 1'b0;
      idx         <= 2'd0;
    end else if (pieces_valid) begin
      piece_valid <= 1'b1;
      piece_last  <= 1'b0;
      draining    <= 1'b1;
      idx         <= 2'd1;
    end else if (draining) begin
      piece_valid <= 1'b1;
      piece_last  <= (idx == 2'd3);
      draining    <= (idx != 2'd3);
      idx         <= idx + 2'd1;
    end else begin
      piece_valid <= 1'b0;
      piece_last  <= 1'b0;
    end
  end

  // payload of the output beats
  always_ff @(posedge clk) begin
    if (pieces_valid) begin
      buf_q   <= pieces;
      piece_x <= pieces[0].x;
      piece_y <= pieces[0].y;
      piece_w <= pieces[0].w;
      piece_h <= pieces[0].h;
    end else if (draining) begin
      piece_x <= buf_q[idx].x;
      piece_y <= buf_q[idx].y;
      piece_w <= buf_q[idx].w;
      piece_h <= buf_q[idx].h;
    end
  end

endmodule

// ===== rtl/core/rs_pipe.sv =====
`timescale 1ns / 1ps

module rs_pipe import rs_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  input  logic      in_valid,
  input  item_t     item,
  output logic      pieces_valid,
  output piece_t    pieces [4]
);

  // stage 1: edges
  logic   v1;
  edges_t e1;
  // stage 2: corner pattern
  logic       v2;
  edges_t     e2;
  logic [3:0] pat2;
  // stage 3: raw sizes
  logic v3;
  raw_t raw3 [4];

  edges_t     e1_next;
  logic [3:0] pat_next;
  coord_t     lx, ty;

  function automatic logic in_base(edges_t e, coord_t px, coord_t py);
    return (px >= e.bx) && (px < e.ex) && (py >= e.by) && (py < e.ey);
  endfunction

  always_comb begin
    e1_next.bx  = {{(XW-CW){item.base_x[CW-1]}}, item.base_x};
    e1_next.by  = {{(XW-CW){item.base_y[CW-1]}}, item.base_y};
    e1_next.mnx = {{(XW-CW){item.cut_x[CW-1]}}, item.cut_x};
    e1_next.mny = {{(XW-CW){item.cut_y[CW-1]}}, item.cut_y};
    e1_next.ex  = e1_next.bx + coord_t'({{(XW-CW){1'b0}}, item.base_w});
    e1_next.ey  = e1_next.by + coord_t'({{(XW-CW){1'b0}}, item.base_h});
    e1_next.mxx = e1_next.mnx + coord_t'({{(XW-CW){1'b0}}, item.cut_w});
    e1_next.mxy = e1_next.mny + coord_t'({{(XW-CW){1'b0}}, item.cut_h});
  end

  always_comb begin
    lx = e1.mnx - coord_t'(1);
    ty = e1.mny - coord_t'(1);
    pat_next = {in_base(e1, lx, ty), in_base(e1, lx, e1.mxy),
                in_base(e1, e1.mxx, ty), in_base(e1, e1.mxx, e1.mxy)};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
      pieces_valid <= 1'b0;
    end else begin
      v1 <= in_valid;
      v2 <= v1;
      v3 <= v2;
      pieces_valid <= v3;
    end
  end

  always_ff @(posedge clk) begin
    ops_t o;
    e1   <= e1_next;
    e2   <= e1;
    pat2 <= pat_next;
    for (int s = 0; s < 4; s++) begin
      o = piece_ops(pat2, 2'(s), e2);
      raw3[s].x <= o.x;
      raw3[s].y <= o.y;
      raw3[s].w <= o.wa - o.wb;
      raw3[s].h <= o.ha - o.hb;
      pieces[s].x <= raw3[s].x[CW-1:0];
      pieces[s].y <= raw3[s].y[CW-1:0];
      pieces[s].w <= sat_size(raw3[s].w);
      pieces[s].h <= sat_size(raw3[s].h);
    end
  end

endmodule

// ===== tb/rectangle_subtract_test.sv =====
`timescale 1ns / 1ps

// stimulus for rectangle_subtract: base/cut rectangle pairs are queued up
// front, handed to the block one start beat at a time by a falling-edge
// driver, and every piece beat is checked against an independent prediction

module rectangle_subtract_test;
  import rs_pkg::*;

  localparam int CYCLE_LIMIT = 100000;
  localparam int DRAIN_CYCLES = 12;   // margin after the last due piece, to catch stray beats
  localparam int PRINT_CAP = 40;

  // one expected piece beat
  typedef struct {
    logic signed [CW-1:0] x;
    logic signed [CW-1:0] y;
    logic [CW-1:0]        w;
    logic [CW-1:0]        h;
    logic                 last;
  } piece_due_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic start = 1'b0;
  item_t drive_pair = '0;

  logic                 busy;
  logic                 piece_valid;
  logic signed [CW-1:0] piece_x;
  logic signed [CW-1:0] piece_y;
  logic [CW-1:0]        piece_w;
  logic [CW-1:0]        piece_h;
  logic                 piece_last;

  item_t      pairs_pending[$];
  piece_due_t pieces_due[$];

  logic pair_taken = 1'b0;
  int   pairs_taken = 0;
  int   mismatches = 0;
  int   cycle_count = 0;

  always #5 clk = ~clk;

  always @(posedge clk) cycle_count <= cycle_count + 1;

  rectangle_subtract i_dut (
    .clk         (clk),
    .rst         (rst),
    .start       (start),
    .busy        (busy),
    .base_x      (drive_pair.base_x),
    .base_y      (drive_pair.base_y),
    .base_w      (drive_pair.base_w),
    .base_h      (drive_pair.base_h),
    .cut_x       (drive_pair.cut_x),
    .cut_y       (drive_pair.cut_y),
    .cut_w       (drive_pair.cut_w),
    .cut_h       (drive_pair.cut_h),
    .piece_valid (piece_valid),
    .piece_x     (piece_x),
    .piece_y     (piece_y),
    .piece_w     (piece_w),
    .piece_h     (piece_h),
    .piece_last  (piece_last)
  );

  // ---------------------------------------------------------------------------
  // prediction
  // ---------------------------------------------------------------------------

  // origin wraps to CW bits, sizes clamp to [0, all ones]
  function automatic piece_due_t piece_of(int slot, longint x, longint y, longint w,
                                          longint h);
    piece_due_t p;
    longint     size_max;
    size_max = (longint'(1) << CW) - 1;
    p.x = x[CW-1:0];
    p.y = y[CW-1:0];
    p.w = (w < 0) ? '0 : (w > size_max) ? '1 : w[CW-1:0];
    p.h = (h < 0) ? '0 : (h > size_max) ? '1 : h[CW-1:0];
    p.last = (slot == 3);
    return p;
  endfunction

  function automatic bit in_base(longint bx, longint by, longint bw, longint bh,
                                 longint px, longint py);
    return bx <= px && px <= bx + bw - 1 && by <= py && py <= by + bh - 1;
  endfunction

  // base minus cut as four pieces, appended to pieces_due in beat order
  function automatic void carve_pieces(item_t p);
    longint     bx, by, bw, bh, ex, ey, mnx, mny, mxx, mxy;
    logic [3:0] corners;
    piece_due_t slot[4];
    bx  = longint'($signed(p.base_x));
    by  = longint'($signed(p.base_y));
    bw  = longint'($unsigned(p.base_w));
    bh  = longint'($unsigned(p.base_h));
    mnx = longint'($signed(p.cut_x));
    mny = longint'($signed(p.cut_y));
    mxx = mnx + longint'($unsigned(p.cut_w));
    mxy = mny + longint'($unsigned(p.cut_h));
    ex  = bx + bw;
    ey  = by + bh;
    // which of the four points just outside the cut corners fall in the base
    corners = {in_base(bx, by, bw, bh, mnx - 1, mny - 1),
               in_base(bx, by, bw, bh, mnx - 1, mxy),
               in_base(bx, by, bw, bh, mxx, mny - 1),
               in_base(bx, by, bw, bh, mxx, mxy)};
    for (int k = 0; k < 4; k++) slot[k] = piece_of(k, 0, 0, 0, 0);
    // the corner set is always a product of an x test and a y test, so the
    // six patterns left to the default arm cannot come up
    case (corners)
      PAT_TL: begin
        slot[0] = piece_of(0, bx, by, bw, mny - by);
        slot[1] = piece_of(1, bx, mny, mnx - bx, ey - mny);
      end
      PAT_BL: begin
        slot[0] = piece_of(0, bx, by, mnx - bx, bh);
        slot[1] = piece_of(1, mnx, mxy, ex - mnx, ey - mxy);
      end
      PAT_TR: begin
        slot[0] = piece_of(0, bx, by, bw, mny - by);
        slot[1] = piece_of(1, mxx, mny, ex - mxx, ey - mny);
      end
      PAT_BR: begin
        slot[0] = piece_of(0, mxx, by, ex - mxx, bh);
        slot[1] = piece_of(1, bx, mxy, mxx - bx, ey - mxy);
      end
      PAT_TL_TR: begin
        slot[0] = piece_of(0, bx, by, bw, mny - by);
        slot[1] = piece_of(1, bx, mny, mnx - bx, ey - mny);
        slot[2] = piece_of(2, mxx, mny, ex - mxx, ey - mny);
      end
      PAT_TR_BR: begin
        slot[0] = piece_of(0, bx, by, bw, mny - by);
        slot[1] = piece_of(1, mxx, mny, ex - mxx, ey - mny);
        slot[2] = piece_of(2, bx, mxy, mxx - bx, ey - mxy);
      end
      PAT_BL_BR: begin
        slot[0] = piece_of(0, bx, by, mnx - bx, bh);
        slot[1] = piece_of(1, mxx, by, ex - mxx, bh);
        slot[2] = piece_of(2, mnx, mxy, mxx - mnx, ey - mxy);
      end
      PAT_TL_BL: begin
        slot[0] = piece_of(0, bx, by, bw, mny - by);
        slot[1] = piece_of(1, bx, mny, mnx - bx, ey - mny);
        slot[2] = piece_of(2, mnx, mxy, ex - mnx, ey - mxy);
      end
      PAT_ALL: begin
        slot[0] = piece_of(0, bx, by, mxx - bx, mny - by);
        slot[1] = piece_of(1, bx, mny, mnx - bx, ey - mny);
        slot[2] = piece_of(2, mnx, mxy, ex - mnx, ey - mxy);
        slot[3] = piece_of(3, mxx, by, ex - mxx, mxy - by);
      end
      PAT_NONE: begin
        // top, left, bottom and right strips, possibly overlapping
        slot[0] = piece_of(0, bx, by, bw, mny - by);
        slot[1] = piece_of(1, bx, by, mnx - bx, bh);
        slot[2] = piece_of(2, bx, mxy, bw, ey - mxy);
        slot[3] = piece_of(3, mxx, by, ex - mxx, bh);
      end
      default: ;
    endcase
    for (int k = 0; k < 4; k++) pieces_due.push_back(slot[k]);
  endfunction

  // ---------------------------------------------------------------------------
  // checking
  // ---------------------------------------------------------------------------

  task automatic report_mismatch(input string what, input longint got, input longint want);
    if (mismatches < PRINT_CAP)
      $display("%0t: mismatch on %s: got %0d, want %0d", $time, what, got, want);
    mismatches++;
  endtask

  // ---------------------------------------------------------------------------
  // driver: new beat offered at the falling edge, start dropped at random
  // ---------------------------------------------------------------------------

  always @(negedge clk) begin
    if (!rst) begin
      bit idle_now;
      // no idling at all for a stretch in the middle of the run
      idle_now = !(pairs_taken >= 150 && pairs_taken < 250) && $urandom_range(99) < 17;
      if (pair_taken) void'(pairs_pending.pop_front());
      if (pairs_pending.size() != 0 && !idle_now) begin
        drive_pair <= pairs_pending[0];
        start <= 1'b1;
      end else begin
        start <= 1'b0;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // monitor: accepted start beats feed the prediction, piece beats are checked
  // ---------------------------------------------------------------------------

  always @(posedge clk) begin
    if (rst) begin
      pair_taken <= 1'b0;
    end else begin
      pair_taken <= start && !busy;
      if (start && !busy) begin
        carve_pieces(drive_pair);
        pairs_taken++;
      end
      if (piece_valid) begin
        if (pieces_due.size() == 0) begin
          report_mismatch("piece beat with nothing due", 1, 0);
        end else begin
          piece_due_t want;
          want = pieces_due.pop_front();
          if (piece_x !== want.x) report_mismatch("piece_x", piece_x, want.x);
          if (piece_y !== want.y) report_mismatch("piece_y", piece_y, want.y);
          if (piece_w !== want.w) report_mismatch("piece_w", piece_w, want.w);
          if (piece_h !== want.h) report_mismatch("piece_h", piece_h, want.h);
          if (piece_last !== want.last)
            report_mismatch("piece_last", piece_last, want.last);
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // stimulus
  // ---------------------------------------------------------------------------

  task automatic add_pair(input int bx, input int by, input int bw, input int bh,
                          input int cx, input int cy, input int cw, input int ch);
    item_t p;
    p.base_x = bx[CW-1:0];
    p.base_y = by[CW-1:0];
    p.base_w = bw[CW-1:0];
    p.base_h = bh[CW-1:0];
    p.cut_x  = cx[CW-1:0];
    p.cut_y  = cy[CW-1:0];
    p.cut_w  = cw[CW-1:0];
    p.cut_h  = ch[CW-1:0];
    pairs_pending.push_back(p);
  endtask

  // boundary values of a 16-bit field, sometimes a random one
  function automatic int edge_value();
    case ($urandom_range(5))
      0: return 0;
      1: return 1;
      2: return 'h7fff;
      3: return 'h8000;
      4: return 'hffff;
      default: return $urandom;
    endcase
  endfunction

  initial begin
    int bx, by, bw, bh;

    // directed: at least one pair per corner pattern on a 100 x 100 base at the origin
    add_pair(0, 0, 100, 100, -10, -10, 200, 200);   // cut swallows the base
    add_pair(0, 0, 100, 100, 500, 500, 10, 10);     // cut far away
    add_pair(0, 0, 100, 100, 50, 50, 100, 100);     // top-left corner only
    add_pair(0, 0, 100, 100, 50, -50, 100, 100);    // bottom-left only
    add_pair(0, 0, 100, 100, -50, 50, 100, 100);    // top-right only
    add_pair(0, 0, 100, 100, -50, -50, 100, 100);   // bottom-right only
    add_pair(0, 0, 100, 100, 20, 50, 40, 100);      // top pair
    add_pair(0, 0, 100, 100, -50, 20, 100, 40);     // right pair
    add_pair(0, 0, 100, 100, 20, -50, 40, 100);     // bottom pair
    add_pair(0, 0, 100, 100, 50, 20, 100, 40);      // left pair
    add_pair(0, 0, 100, 100, 20, 20, 40, 40);       // hole in the middle
    add_pair(0, 0, 100, 100, 20, 20, 0, 0);         // zero-size cut inside
    // field extremes
    add_pair(0, 0, 0, 0, 0, 0, 0, 0);
    add_pair(-32768, -32768, 65535, 65535, 0, 0, 10, 10);
    add_pair(-32768, -32768, 65535, 65535, 32767, 32767, 65535, 65535);
    add_pair(32767, 32767, 65535, 65535, -32768, -32768, 0, 0);  // sizes clamp high
    add_pair(32767, 32767, 65535, 65535, 32767, 32767, 65535, 65535);
    add_pair(-32768, -32768, 0, 0, 32767, 32767, 65535, 65535);
    add_pair(100, 100, 10, 10, -32768, -32768, 65535, 65535);    // sizes go negative
    add_pair(-1, -1, 1, 1, 0, 0, 0, 0);
    add_pair(-32768, 32767, 65535, 1, -32768, 32767, 1, 65535);

    // random: mostly cuts placed around the base so every pattern comes up
    for (int n = 0; n < 480; n++) begin
      case ($urandom_range(19))
        0, 1, 2, 3, 4: begin
          add_pair($urandom, $urandom, $urandom, $urandom,
                   $urandom, $urandom, $urandom, $urandom);
        end
        5, 6: begin
          add_pair(edge_value(), edge_value(), edge_value(), edge_value(),
                   edge_value(), edge_value(), edge_value(), edge_value());
        end
        default: begin
          bx = $urandom;
          by = $urandom;
          bw = ($urandom_range(9) == 0) ? $urandom : $urandom_range(200);
          bh = ($urandom_range(9) == 0) ? $urandom : $urandom_range(200);
          add_pair(bx, by, bw, bh,
                   bx + $urandom_range(260) - 30, by + $urandom_range(260) - 30,
                   $urandom_range(220), $urandom_range(220));
        end
      endcase
    end

    repeat (9) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // run until every pair is in and every piece is out, or until the limit
    fork
      begin
        while (pairs_pending.size() != 0 || pieces_due.size() != 0) @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
      end
      while (cycle_count < CYCLE_LIMIT) @(posedge clk);
    join_any
    disable fork;

    if (cycle_count < CYCLE_LIMIT && mismatches == 0) begin
      $display("[rectangle_subtract] OK");
    end else begin
      $display("[rectangle_subtract] ERROR");
    end
    $finish;
  end

endmodule
